FILE: design/crpm_pkg.sv
// Shared types and constants for the capture tachometer speed core.
package crpm_pkg;

  localparam int TIMER_BITS = 16;
  localparam int PERIOD_W   = TIMER_BITS;
  localparam int SPEED_W    = 26;
  localparam int TICKS_W    = 4;
  localparam int PPR_W      = 5;
  localparam int DIVISOR_W  = PERIOD_W + PPR_W;
  localparam int DIV_STEPS  = SPEED_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = SPEED_W;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RPM_NUMERATOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSES_PER_REV = 3'd4;

  // Reset values of the configuration registers
  localparam logic [PERIOD_W-1:0] RST_MIN_PERIOD    = 16'd100;
  localparam logic [TICKS_W-1:0]  RST_TIMEOUT_TICKS = 4'd10;
  localparam logic [SPEED_W-1:0]  RST_MAX_STEP      = 26'd1000;
  localparam logic [SPEED_W-1:0]  RST_RPM_NUMERATOR = 26'd60000000;
  localparam logic [PPR_W-1:0]    RST_PULSES_PER_REV = 5'd6;

  typedef struct packed {
    logic                op;
    logic [PERIOD_W-1:0] capture_time;
  } in_item_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_rpm;
    logic               capture_taken;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic setup;
    logic step;
    logic adopt;
    logic commit;
  } crpm_cmd_t;

  typedef struct packed {
    logic period_ok;
  } crpm_sts_t;

endpackage

FILE: design/crpm_datapath.sv
// Datapath: config registers, period, divisor, serial divider and speed state.
module crpm_datapath import crpm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  in_item_t             in_item,
  input  crpm_cmd_t            cmd,
  output crpm_sts_t            sts,
  output out_item_t            out_item
);

  logic [PERIOD_W-1:0]  min_period_r;
  logic [TICKS_W-1:0]   timeout_r;
  logic [SPEED_W-1:0]   max_step_r;
  logic [SPEED_W-1:0]   rpm_num_r;
  logic [PPR_W-1:0]     ppr_r;

  logic                 op_r;
  logic [PERIOD_W-1:0]  now_r;
  logic [PERIOD_W-1:0]  period_r;
  logic [DIVISOR_W-1:0] divisor_r;
  logic [DIVISOR_W-1:0] rem_r;
  logic [SPEED_W-1:0]   quo_r;
  logic                 adopt_r;

  logic [PERIOD_W-1:0]  last_stamp_r, last_stamp_nxt;
  logic [SPEED_W-1:0]   held_r, held_nxt;
  logic [TICKS_W-1:0]   idle_r, idle_nxt;
  out_item_t            out_r;

  logic [PERIOD_W-1:0]  period_new;
  logic [DIVISOR_W:0]   rem_sh;
  logic [DIVISOR_W:0]   rem_sub;
  logic                 rem_ge;
  logic [SPEED_W-1:0]   diff;
  logic [TICKS_W-1:0]   idle_inc;
  logic                 taken;

  // Wrapped stamp: new + max - old is new - old - 1 modulo the timer width
  assign period_new = (in_item.capture_time > last_stamp_r) ?
                      (in_item.capture_time - last_stamp_r) :
                      (in_item.capture_time - last_stamp_r - PERIOD_W'(1));

  assign sts.period_ok = (period_r >= min_period_r);

  // Restoring divider step; a zero divisor yields all ones in the quotient
  assign rem_sh  = {rem_r, quo_r[SPEED_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, divisor_r});
  assign rem_sub = rem_sh - {1'b0, divisor_r};

  assign diff = (quo_r > held_r) ? (quo_r - held_r) : (held_r - quo_r);

  assign idle_inc = idle_r + TICKS_W'(1);

  always_comb begin
    last_stamp_nxt = last_stamp_r;
    held_nxt       = held_r;
    idle_nxt       = idle_r;
    taken          = 1'b0;
    if (op_r) begin
      if (sts.period_ok) begin
        last_stamp_nxt = now_r;
        idle_nxt       = '0;
        taken          = 1'b1;
        if (adopt_r) begin
          held_nxt = quo_r;
        end
      end
    end else begin
      if (idle_inc >= timeout_r) begin
        held_nxt = '0;
        idle_nxt = '0;
      end else begin
        idle_nxt = idle_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_period_r <= RST_MIN_PERIOD;
      timeout_r    <= RST_TIMEOUT_TICKS;
      max_step_r   <= RST_MAX_STEP;
      rpm_num_r    <= RST_RPM_NUMERATOR;
      ppr_r        <= RST_PULSES_PER_REV;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MIN_PERIOD:     min_period_r <= cfg_data[PERIOD_W-1:0];
        CFG_TIMEOUT_TICKS:  timeout_r    <= cfg_data[TICKS_W-1:0];
        CFG_MAX_STEP:       max_step_r   <= cfg_data[SPEED_W-1:0];
        CFG_RPM_NUMERATOR:  rpm_num_r    <= cfg_data[SPEED_W-1:0];
        CFG_PULSES_PER_REV: ppr_r        <= cfg_data[PPR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_stamp_r <= '0;
      held_r       <= '0;
      idle_r       <= '0;
    end else if (cmd.commit) begin
      last_stamp_r <= last_stamp_nxt;
      held_r       <= held_nxt;
      idle_r       <= idle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_item.op;
      now_r    <= in_item.capture_time;
      period_r <= period_new;
    end
    if (cmd.setup) begin
      divisor_r <= DIVISOR_W'(period_r) * DIVISOR_W'(ppr_r);
      rem_r     <= '0;
      quo_r     <= rpm_num_r;
    end
    if (cmd.step) begin
      rem_r <= rem_ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
      quo_r <= {quo_r[SPEED_W-2:0], rem_ge};
    end
    if (cmd.adopt) begin
      adopt_r <= (diff != '0) && (diff < max_step_r);
    end
    if (cmd.commit) begin
      out_r.speed_rpm     <= held_nxt;
      out_r.capture_taken <= taken;
    end
  end

  assign out_item = out_r;

endmodule

FILE: design/crpm_ctrl.sv
// Controller: sequences load, period check, divide, compare and commit.
module crpm_ctrl import crpm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_op,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  crpm_sts_t sts,
  output crpm_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_ADOPT,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_cnt_r, step_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load   = in_valid && (state_r == S_IDLE);
    cmd.setup  = (state_r == S_CHECK) && sts.period_ok;
    cmd.step   = (state_r == S_DIV);
    cmd.adopt  = (state_r == S_ADOPT);
    cmd.commit = (state_r == S_DONE) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt     = state_r;
    step_cnt_nxt  = step_cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = in_op ? S_CHECK : S_DONE;
        end
      end
      S_CHECK: begin
        step_cnt_nxt = '0;
        // skip the divide for a glitch capture
        state_nxt    = sts.period_ok ? S_DIV : S_DONE;
      end
      S_DIV: begin
        step_cnt_nxt = step_cnt_r + STEP_W'(1);
        if (step_cnt_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_ADOPT;
        end
      end
      S_ADOPT: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (cmd.commit) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_cnt_r  <= step_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_commit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_ready))
    else $error("commit while output register is occupied");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("committed item not presented");

  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_ready)
    else $error("new item taken while one is in progress");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (step_cnt_r <= STEP_W'(DIV_STEPS - 1)))
    else $error("divider step count overran");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.setup, cmd.step, cmd.adopt, cmd.commit}))
    else $error("more than one datapath command at once");

endmodule

FILE: design/capture_tachometer_rpm_core.sv
// Tachometer core: capture stamps and timeout ticks in, held speed in rpm out.
// A capture that passes the period check goes through check, 26 divider steps,
// compare and commit after acceptance; a rejected capture through check and commit.
// A tick goes straight to commit. One item at a time, through the one-bit-per-cycle
// restoring divider; a result waits in the output register.
// Synchronous active-low reset restores register defaults and clears stamp, speed, ticks.
module capture_tachometer_rpm_core import crpm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item
);

  crpm_cmd_t cmd;
  crpm_sts_t sts;

  assign cfg_ready = 1'b1;

  crpm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_item.op),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  crpm_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_item)
  );

endmodule
